// ===== design/ffra_pkg.sv =====
`default_nettype none

package ffra_pkg;

	// Default sizes of the two tables and the address width.
	localparam int FREE_SLOTS_DEF = 64;
	localparam int LIVE_SLOTS_DEF = 256;
	localparam int ADDR_BITS_DEF  = 48;

	// Fixed field widths.
	localparam int ALIGN_BITS  = 33;
	localparam int OFFSET_BITS = 32;
	localparam int CMD_BITS    = 2;
	localparam int STAT_BITS   = 2;

	// Command codes.
	localparam logic [CMD_BITS-1:0] CMD_INIT  = 2'd0;
	localparam logic [CMD_BITS-1:0] CMD_ALLOC = 2'd1;
	localparam logic [CMD_BITS-1:0] CMD_FREE  = 2'd2;

	// Status codes.
	localparam logic [STAT_BITS-1:0] ST_OK       = 2'd0;
	localparam logic [STAT_BITS-1:0] ST_NO_SPACE = 2'd1;
	localparam logic [STAT_BITS-1:0] ST_NOT_FND  = 2'd2;
	localparam logic [STAT_BITS-1:0] ST_FULL     = 2'd3;

	// Register indexes.
	localparam logic REG_BASE = 1'b0;
	localparam logic REG_SIZE = 1'b1;

endpackage

`default_nettype wire

// ===== design/ffra_mod.sv =====
`default_nettype none

// Restoring remainder unit: one dividend bit per cycle.
module ffra_mod
	import ffra_pkg::*;
#(
	parameter int ADDR_BITS = ADDR_BITS_DEF
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   start,
	input  wire [ADDR_BITS-1:0]   dividend,
	input  wire [ALIGN_BITS-1:0]  divisor,
	output logic                  done,
	output logic [ALIGN_BITS-1:0] rem
);

	localparam int CNTW = $clog2(ADDR_BITS + 1);

	logic                  busy_q;
	logic                  done_q;
	logic [CNTW-1:0]       cnt_q;
	logic [ADDR_BITS-1:0]  dvd_q;
	logic [ALIGN_BITS-1:0] div_q;
	logic [ALIGN_BITS-1:0] r_q;
	logic [ALIGN_BITS:0]   trial;
	logic [ALIGN_BITS:0]   diff;
	logic [ALIGN_BITS-1:0] r_next;

	// Shift in the next dividend bit and subtract the divisor when it fits.
	always_comb begin
		trial  = {r_q, dvd_q[ADDR_BITS-1]};
		diff   = trial - {1'b0, div_q};
		r_next = (trial >= {1'b0, div_q}) ? diff[ALIGN_BITS-1:0] : trial[ALIGN_BITS-1:0];
	end

	// Control of the iteration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(ADDR_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath of the iteration.
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			div_q <= divisor;
			r_q   <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[ADDR_BITS-2:0], 1'b0};
			r_q   <= r_next;
		end
	end

	assign done = done_q;
	assign rem  = r_q;

endmodule

`default_nettype wire

// ===== design/first_fit_range_allocator_unit.sv =====
`default_nettype none

// Steps: allocate runs a free list scan, the remainder unit, a live table scan and
// list compaction when a range is used up; free runs a live table scan, a free list
// position scan, a merge and, when needed, a list shift.
// One command is worked on at a time; the scans run one memory read per cycle.
// Reset clears the free count, the live valid bits and the output valid; no memory sweep.
module first_fit_range_allocator_unit
	import ffra_pkg::*;
#(
	parameter int FREE_SLOTS = FREE_SLOTS_DEF,
	parameter int LIVE_SLOTS = LIVE_SLOTS_DEF,
	parameter int ADDR_BITS  = ADDR_BITS_DEF,
	localparam int IN_W    = 2 * ADDR_BITS + ALIGN_BITS + OFFSET_BITS,
	localparam int IN_PAD  = ((IN_W + 7) / 8) * 8,
	localparam int OUT_W   = ADDR_BITS + STAT_BITS,
	localparam int OUT_PAD = ((OUT_W + 7) / 8) * 8
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cfg_we,
	input  wire                 cfg_index,
	input  wire [ADDR_BITS-1:0] cfg_wdata,
	input  wire                 s_tvalid,
	output logic                s_tready,
	// request_size, align_bytes, extra_offset, release_address
	input  wire [IN_PAD-1:0]    s_tdata,
	// command
	input  wire [CMD_BITS-1:0]  s_tuser,
	output logic                m_tvalid,
	input  wire                 m_tready,
	// granted_address, status
	output logic [OUT_PAD-1:0]  m_tdata
);

	localparam int A   = ADDR_BITS;
	localparam int CW  = $clog2(FREE_SLOTS + 1);
	localparam int IW  = $clog2(FREE_SLOTS);
	localparam int LCW = $clog2(LIVE_SLOTS + 1);
	localparam int LW  = $clog2(LIVE_SLOTS);
	localparam int NW  = A + 2;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_INIT   = 4'd1;
	localparam logic [3:0] S_FSCAN  = 4'd2;
	localparam logic [3:0] S_MODW   = 4'd3;
	localparam logic [3:0] S_LSCAN  = 4'd4;
	localparam logic [3:0] S_ACOMM  = 4'd5;
	localparam logic [3:0] S_FPOS   = 4'd6;
	localparam logic [3:0] S_FMERGE = 4'd7;
	localparam logic [3:0] S_SHDN   = 4'd8;
	localparam logic [3:0] S_SHUP   = 4'd9;
	localparam logic [3:0] S_DONE   = 4'd10;

	// Configuration.
	logic [A-1:0] region_base_q;
	logic [A-1:0] region_size_q;

	// Memories and their ports.
	logic [2*A-1:0] fmem [FREE_SLOTS];
	logic [3*A-1:0] lmem [LIVE_SLOTS];
	logic           fm_we;
	logic [IW-1:0]  fm_waddr;
	logic [IW-1:0]  fm_raddr;
	logic [2*A-1:0] fm_wdata;
	logic [2*A-1:0] fm_rd_q;
	logic           lm_we;
	logic [LW-1:0]  lm_waddr;
	logic [3*A-1:0] lm_wdata;
	logic [3*A-1:0] lm_rd_q;

	// Sequencer state.
	logic [3:0]            state_q;
	logic                  ph_q;
	logic [CW-1:0]         k_q;
	logic [CW-1:0]         fidx_q;
	logic [LCW-1:0]        lidx_q;
	logic                  chk_s1;
	logic [IW-1:0]         fchk_s1;
	logic [LW-1:0]         lchk_s1;
	logic [CW-1:0]         count_q;
	logic [LIVE_SLOTS-1:0] valid_q;
	logic                  have_slot_q;
	logic [LW-1:0]         slot_q;

	// Command payload and working values.
	logic [CMD_BITS-1:0]    cmd_q;
	logic [ALIGN_BITS-1:0]  align_q;
	logic [OFFSET_BITS-1:0] off_q;
	logic [A-1:0]           rel_q;
	logic [NW-1:0]          need_q;
	logic [CW-1:0]          pos_q;
	logic [A-1:0]           fbase_q;
	logic [A-1:0]           flen_q;
	logic [A-1:0]           cur_b_q;
	logic [A-1:0]           cur_l_q;
	logic [A-1:0]           prev_b_q;
	logic [A-1:0]           prev_l_q;
	logic [A-1:0]           ret_q;
	logic [A-1:0]           addr_q;
	logic [STAT_BITS-1:0]   stat_q;

	// Input fields.
	logic [A-1:0]           in_size;
	logic [ALIGN_BITS-1:0]  in_align;
	logic [OFFSET_BITS-1:0] in_off;
	logic [A-1:0]           in_rel;
	logic [ALIGN_BITS-1:0]  in_align_eff;

	assign in_size      = s_tdata[A-1:0];
	assign in_align     = s_tdata[A+ALIGN_BITS-1:A];
	assign in_off       = s_tdata[A+ALIGN_BITS+OFFSET_BITS-1:A+ALIGN_BITS];
	assign in_rel       = s_tdata[IN_W-1:A+ALIGN_BITS+OFFSET_BITS];
	assign in_align_eff = (in_align == '0) ? ALIGN_BITS'(1) : in_align;

	// Read data fields.
	logic [A-1:0] rd_base;
	logic [A-1:0] rd_len;
	logic [A-1:0] lm_key;
	logic [A-1:0] lm_base;
	logic [A-1:0] lm_len;

	assign rd_base = fm_rd_q[2*A-1:A];
	assign rd_len  = fm_rd_q[A-1:0];
	assign lm_key  = lm_rd_q[3*A-1:2*A];
	assign lm_base = lm_rd_q[2*A-1:A];
	assign lm_len  = lm_rd_q[A-1:0];

	// Remainder of the chosen base by the alignment.
	logic                  mod_start;
	logic                  mod_done;
	logic [ALIGN_BITS-1:0] mod_rem;
	logic [ALIGN_BITS-1:0] align_eff;
	logic [ALIGN_BITS-1:0] adj;

	assign align_eff = (align_q == '0) ? ALIGN_BITS'(1) : align_q;
	assign adj       = (mod_rem != '0) ? (align_eff - mod_rem) : '0;

	ffra_mod #(
		.ADDR_BITS(ADDR_BITS)
	) u_mod (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mod_start),
		.dividend(rd_base),
		.divisor (align_eff),
		.done    (mod_done),
		.rem     (mod_rem)
	);

	// Scan decisions.
	logic          f_issue;
	logic          l_issue;
	logic          fit_hit;
	logic          pos_hit;
	logic [A-1:0]  key_tgt;
	logic          key_hit;
	logic [CW-1:0] k_inc;
	logic [CW-1:0] k_dec;
	logic [CW-1:0] pos_dec;
	logic [A-1:0]  alloc_len;
	logic [A-1:0]  alloc_base;
	logic [A:0]    free_end;
	logic          left;
	logic          right;
	logic          list_full;

	// The neighbor checks compare full sums, so a range that runs past the top
	// of the address space never touches one at the bottom.
	always_comb begin
		f_issue    = fidx_q < count_q;
		l_issue    = lidx_q < LCW'(LIVE_SLOTS);
		fit_hit    = chk_s1 && ({2'b00, rd_len} >= need_q);
		pos_hit    = chk_s1 && (rd_base >= fbase_q);
		key_tgt    = (cmd_q == CMD_ALLOC) ? ret_q : rel_q;
		key_hit    = chk_s1 && valid_q[lchk_s1] && (lm_key == key_tgt);
		k_inc      = k_q + 1'b1;
		k_dec      = k_q - 1'b1;
		pos_dec    = pos_q - 1'b1;
		alloc_len  = flen_q - need_q[A-1:0];
		alloc_base = fbase_q + need_q[A-1:0];
		free_end   = {1'b0, fbase_q} + {1'b0, flen_q};
		left       = (pos_q != '0)
			&& (({1'b0, prev_b_q} + {1'b0, prev_l_q}) == {1'b0, fbase_q});
		right      = (pos_q < count_q) && ({1'b0, cur_b_q} == free_end);
		list_full  = count_q >= CW'(FREE_SLOTS);
		mod_start  = (state_q == S_FSCAN) && fit_hit;
	end

	// Memory port control.
	always_comb begin
		fm_we    = 1'b0;
		fm_waddr = '0;
		fm_wdata = '0;
		fm_raddr = fidx_q[IW-1:0];
		lm_we    = 1'b0;
		lm_waddr = slot_q;
		lm_wdata = {ret_q, fbase_q, need_q[A-1:0]};
		case (state_q)
			S_INIT: begin
				fm_we    = 1'b1;
				fm_wdata = {region_base_q, region_size_q};
			end
			S_ACOMM: begin
				fm_we    = alloc_len != '0;
				fm_waddr = pos_q[IW-1:0];
				fm_wdata = {alloc_base, alloc_len};
				lm_we    = 1'b1;
			end
			S_FMERGE: begin
				if (left && right) begin
					fm_we    = 1'b1;
					fm_waddr = pos_dec[IW-1:0];
					fm_wdata = {prev_b_q, prev_l_q + flen_q + cur_l_q};
				end else if (left) begin
					fm_we    = 1'b1;
					fm_waddr = pos_dec[IW-1:0];
					fm_wdata = {prev_b_q, prev_l_q + flen_q};
				end else if (right) begin
					fm_we    = 1'b1;
					fm_waddr = pos_q[IW-1:0];
					fm_wdata = {fbase_q, cur_l_q + flen_q};
				end
			end
			S_SHDN: begin
				fm_raddr = k_inc[IW-1:0];
				fm_we    = ph_q;
				fm_waddr = k_q[IW-1:0];
				fm_wdata = fm_rd_q;
			end
			S_SHUP: begin
				fm_raddr = k_dec[IW-1:0];
				if (ph_q) begin
					fm_we    = 1'b1;
					fm_waddr = k_q[IW-1:0];
					fm_wdata = fm_rd_q;
				end else if (k_q <= pos_q) begin
					fm_we    = 1'b1;
					fm_waddr = pos_q[IW-1:0];
					fm_wdata = {fbase_q, flen_q};
				end
			end
			default: begin
			end
		endcase
	end

	// Free list and live table memories.
	always_ff @(posedge clk) begin
		if (fm_we) begin
			fmem[fm_waddr] <= fm_wdata;
		end
		fm_rd_q <= fmem[fm_raddr];
	end

	always_ff @(posedge clk) begin
		if (lm_we) begin
			lmem[lm_waddr] <= lm_wdata;
		end
		lm_rd_q <= lmem[lidx_q[LW-1:0]];
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_base_q <= '0;
			region_size_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == REG_BASE) begin
				region_base_q <= cfg_wdata;
			end else begin
				region_size_q <= cfg_wdata;
			end
		end
	end

	assign s_tready = state_q == S_IDLE;

	// Command sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ph_q        <= 1'b0;
			k_q         <= '0;
			fidx_q      <= '0;
			lidx_q      <= '0;
			chk_s1      <= 1'b0;
			count_q     <= '0;
			valid_q     <= '0;
			have_slot_q <= 1'b0;
			m_tvalid    <= 1'b0;
		end else begin
			// The output word is loaded from the done state, else drained by ready.
			if (state_q == S_DONE && (!m_tvalid || m_tready)) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						chk_s1      <= 1'b0;
						fidx_q      <= '0;
						lidx_q      <= '0;
						have_slot_q <= 1'b0;
						case (s_tuser)
							CMD_INIT:  state_q <= S_INIT;
							CMD_ALLOC: state_q <= S_FSCAN;
							CMD_FREE:  state_q <= S_LSCAN;
							default:   state_q <= S_DONE;
						endcase
					end
				end
				S_INIT: begin
					valid_q <= '0;
					count_q <= (region_size_q != '0) ? CW'(1) : '0;
					state_q <= S_DONE;
				end
				S_FSCAN, S_FPOS: begin
					chk_s1 <= f_issue && !(state_q == S_FSCAN && fit_hit);
					if (f_issue) begin
						fidx_q <= fidx_q + 1'b1;
					end
					if (state_q == S_FSCAN) begin
						if (fit_hit) begin
							state_q <= S_MODW;
						end else if (!chk_s1 && !f_issue) begin
							state_q <= S_DONE;
						end
					end else begin
						if (pos_hit) begin
							state_q <= S_FMERGE;
						end else if (!chk_s1 && !f_issue) begin
							state_q <= S_FMERGE;
						end
					end
				end
				S_MODW: begin
					if (mod_done) begin
						chk_s1  <= 1'b0;
						lidx_q  <= '0;
						state_q <= S_LSCAN;
					end
				end
				S_LSCAN: begin
					chk_s1 <= l_issue && !key_hit;
					if (l_issue) begin
						lidx_q <= lidx_q + 1'b1;
					end
					if (chk_s1 && !valid_q[lchk_s1] && !have_slot_q) begin
						have_slot_q <= 1'b1;
					end
					if (key_hit) begin
						if (cmd_q == CMD_ALLOC) begin
							state_q <= S_ACOMM;
						end else if (lm_len == '0) begin
							valid_q[lchk_s1] <= 1'b0;
							state_q          <= S_DONE;
						end else begin
							fidx_q  <= '0;
							state_q <= S_FPOS;
						end
					end else if (!chk_s1 && !l_issue) begin
						if (cmd_q == CMD_ALLOC && have_slot_q) begin
							state_q <= S_ACOMM;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_ACOMM: begin
					valid_q[slot_q] <= 1'b1;
					if (alloc_len == '0) begin
						k_q     <= pos_q;
						ph_q    <= 1'b0;
						state_q <= S_SHDN;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_FMERGE: begin
					ph_q <= 1'b0;
					if (!left && !right && list_full) begin
						state_q <= S_DONE;
					end else begin
						valid_q[slot_q] <= 1'b0;
						if (left && right) begin
							k_q     <= pos_q;
							state_q <= S_SHDN;
						end else if (left || right) begin
							state_q <= S_DONE;
						end else begin
							k_q     <= count_q;
							state_q <= S_SHUP;
						end
					end
				end
				S_SHDN: begin
					if (ph_q) begin
						k_q  <= k_inc;
						ph_q <= 1'b0;
					end else if (k_inc < count_q) begin
						ph_q <= 1'b1;
					end else begin
						count_q <= count_q - 1'b1;
						state_q <= S_DONE;
					end
				end
				S_SHUP: begin
					if (ph_q) begin
						k_q  <= k_dec;
						ph_q <= 1'b0;
					end else if (k_q > pos_q) begin
						ph_q <= 1'b1;
					end else begin
						count_q <= count_q + 1'b1;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!m_tvalid || m_tready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Working registers of the sequencer.
	always_ff @(posedge clk) begin
		if (chk_s1 == 1'b0 || state_q != S_IDLE) begin
			fchk_s1 <= fidx_q[IW-1:0];
			lchk_s1 <= lidx_q[LW-1:0];
		end
		case (state_q)
			S_IDLE: begin
				cmd_q   <= s_tuser;
				align_q <= in_align;
				off_q   <= in_off;
				rel_q   <= in_rel;
				need_q  <= {2'b00, in_size} + NW'(in_off) + NW'(in_align_eff - 1'b1);
				addr_q  <= '0;
				stat_q  <= ST_OK;
			end
			S_FSCAN: begin
				if (fit_hit) begin
					fbase_q <= rd_base;
					flen_q  <= rd_len;
					pos_q   <= CW'(fchk_s1);
				end else if (!chk_s1 && !f_issue) begin
					stat_q <= ST_NO_SPACE;
				end
			end
			S_MODW: begin
				if (mod_done) begin
					ret_q <= fbase_q + A'(adj) + A'(off_q);
				end
			end
			S_LSCAN: begin
				if (chk_s1 && !valid_q[lchk_s1] && !have_slot_q) begin
					slot_q <= lchk_s1;
				end
				if (key_hit) begin
					slot_q <= lchk_s1;
					if (cmd_q == CMD_FREE) begin
						fbase_q <= lm_base;
						flen_q  <= lm_len;
					end
				end else if (!chk_s1 && !l_issue) begin
					if (cmd_q == CMD_FREE) begin
						stat_q <= ST_NOT_FND;
					end else if (!have_slot_q) begin
						stat_q <= ST_FULL;
					end
				end
			end
			S_ACOMM: begin
				addr_q <= ret_q;
			end
			S_FPOS: begin
				if (pos_hit) begin
					pos_q   <= CW'(fchk_s1);
					cur_b_q <= rd_base;
					cur_l_q <= rd_len;
				end else if (chk_s1) begin
					prev_b_q <= rd_base;
					prev_l_q <= rd_len;
				end else if (!f_issue) begin
					pos_q <= count_q;
				end
			end
			S_FMERGE: begin
				if (!left && !right && list_full) begin
					stat_q <= ST_FULL;
				end
			end
			S_DONE: begin
				if (!m_tvalid || m_tready) begin
					m_tdata <= OUT_PAD'({stat_q, addr_q});
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire
